FILE: src/wltp_pkg.sv
// Package for the weighted lottery task picker: sizes, register indexes and
// the payload type carried between the modulo pipeline stages. No dependencies.
`default_nettype none

package wltp_pkg;

    // Task set size and the widths that follow from it.
    localparam int MAX_TASKS = 4;
    localparam int TASK_W    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int NACT_W    = $clog2(MAX_TASKS + 1);
    localparam int MASK_W    = MAX_TASKS;

    // Field widths of the request, the result and the registers.
    localparam int WORD_W    = 31;
    localparam int WEIGHT_W  = 16;
    localparam int CNT_W     = 3;
    localparam int CFG_IDX_W = $clog2(MAX_TASKS + 1);
    localparam int CFG_DAT_W = WEIGHT_W;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_TASK_COUNT      = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CUM_WEIGHT_BASE = CFG_IDX_W'(1);
    localparam int                   REG_CUM_WEIGHT_LAST = MAX_TASKS;

    // Restoring modulo: quotient bits retired per stage and stage count.
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (WORD_W + DIV_STEP - 1) / DIV_STEP;
    localparam int DIV_W      = DIV_STAGES * DIV_STEP;

    // Payload of one modulo pipeline stage.
    typedef struct packed {
        logic [WEIGHT_W-1:0] rem;
        logic [DIV_W-1:0]    word;
        logic [MASK_W-1:0]   mask;
    } t_div_data;

endpackage

`default_nettype wire

FILE: src/wltp_ifs.sv
// Channel interfaces of the weighted lottery task picker: request, result and
// configuration write. Depends on wltp_pkg.
`default_nettype none

interface wltp_req_if import wltp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] random_word;
    logic [MASK_W-1:0] ready_mask;

    modport source (output valid, random_word, ready_mask, input ready);
    modport sink   (input valid, random_word, ready_mask, output ready);
endinterface

interface wltp_rsp_if import wltp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TASK_W-1:0]   task_index;
    logic                none_ready;
    logic [WEIGHT_W-1:0] ticket;

    modport source (output valid, task_index, none_ready, ticket, input ready);
    modport sink   (input valid, task_index, none_ready, ticket, output ready);
endinterface

interface wltp_cfg_if import wltp_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: src/weighted_lottery_task_picker.sv
// Weighted lottery task picker: one request per cycle, ten register stages.
// Path: each request passes eight modulo stages, one winner stage and one output
// stage, each registered, and waits in place under stalls.
// Throughput: one transaction per cycle; each stage stalls only when full.
// Reset (synchronous, active low) empties the pipeline and restores the
// registers to task_count 4 and cumulative weights 1, 2, 3, 4.
`default_nettype none

module weighted_lottery_task_picker import wltp_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    wltp_req_if.sink    i_req,
    wltp_cfg_if.sink    i_cfg,
    wltp_rsp_if.source  o_rsp
);

    // Configuration registers.
    logic [CNT_W-1:0]    r_task_count;
    logic [WEIGHT_W-1:0] r_cum_weight [MAX_TASKS];
    logic [CFG_IDX_W-1:0] cfg_sel;

    assign i_cfg.ready = 1'b1;
    assign cfg_sel     = i_cfg.index - REG_CUM_WEIGHT_BASE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_task_count <= CNT_W'(MAX_TASKS);
            for (int i = 0; i < MAX_TASKS; i++) begin
                r_cum_weight[i] <= WEIGHT_W'(i + 1);
            end
        end else if (i_cfg.valid) begin
            if (i_cfg.index == REG_TASK_COUNT) begin
                r_task_count <= i_cfg.data[CNT_W-1:0];
            end else if (int'(i_cfg.index) <= REG_CUM_WEIGHT_LAST) begin
                r_cum_weight[cfg_sel[TASK_W-1:0]] <= i_cfg.data;
            end
        end
    end

    // Active task count, clamped to one through MAX_TASKS, and the total weight.
    logic [NACT_W-1:0]   n_act;
    logic [TASK_W-1:0]   last_idx;
    logic [WEIGHT_W-1:0] total;

    always_comb begin
        if (r_task_count == '0) begin
            n_act = NACT_W'(1);
        end else if (int'(r_task_count) > MAX_TASKS) begin
            n_act = NACT_W'(MAX_TASKS);
        end else begin
            n_act = NACT_W'(r_task_count);
        end
    end

    assign last_idx = TASK_W'(n_act - NACT_W'(1));
    assign total    = r_cum_weight[last_idx];

    // Modulo pipeline: the random word is reduced modulo the total weight.
    logic      s_valid [DIV_STAGES+1];
    logic      s_ready [DIV_STAGES+1];
    t_div_data s_data  [DIV_STAGES+1];

    assign s_valid[0]     = i_req.valid;
    assign i_req.ready    = s_ready[0];
    assign s_data[0].rem  = '0;
    assign s_data[0].word = DIV_W'(i_req.random_word);
    assign s_data[0].mask = i_req.ready_mask;

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_mod
        wltp_mod_stage u_stage (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_divisor (total),
            .i_valid   (s_valid[g]),
            .o_ready   (s_ready[g]),
            .i_data    (s_data[g]),
            .o_valid   (s_valid[g+1]),
            .i_ready   (s_ready[g+1]),
            .o_data    (s_data[g+1])
        );
    end

    // Winner stage: the first active task whose cumulative weight exceeds the ticket.
    logic                r_win_valid;
    logic [WEIGHT_W-1:0] r_win_ticket;
    logic [TASK_W-1:0]   r_win_idx;
    logic [MASK_W-1:0]   r_win_mask;
    logic [WEIGHT_W-1:0] n_win_ticket;
    logic [TASK_W-1:0]   n_win_idx;
    logic                win_ready;
    logic                out_ready;

    assign n_win_ticket = (total == '0) ? '0 : s_data[DIV_STAGES].rem;

    always_comb begin
        n_win_idx = '0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            if (i < int'(n_act) && r_cum_weight[i] > n_win_ticket) begin
                n_win_idx = TASK_W'(i);
            end
        end
    end

    assign win_ready           = !r_win_valid || out_ready;
    assign s_ready[DIV_STAGES] = win_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_valid <= 1'b0;
        end else if (win_ready) begin
            r_win_valid <= s_valid[DIV_STAGES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (win_ready && s_valid[DIV_STAGES]) begin
            r_win_ticket <= n_win_ticket;
            r_win_idx    <= n_win_idx;
            r_win_mask   <= s_data[DIV_STAGES].mask;
        end
    end

    // Output stage: scan forward from the winner, wrapping, to the next ready task.
    logic                r_out_valid;
    logic [TASK_W-1:0]   r_out_index;
    logic                r_out_none;
    logic [WEIGHT_W-1:0] r_out_ticket;
    logic [TASK_W-1:0]   n_pick;
    logic                n_found;

    always_comb begin
        logic [NACT_W:0] t;
        n_pick  = '0;
        n_found = 1'b0;
        for (int i = MAX_TASKS - 1; i >= 0; i--) begin
            t = (NACT_W+1)'(r_win_idx) + (NACT_W+1)'(i);
            if (t >= (NACT_W+1)'(n_act)) begin
                t = t - (NACT_W+1)'(n_act);
            end
            if (i < int'(n_act) && r_win_mask[t[TASK_W-1:0]]) begin
                n_pick  = t[TASK_W-1:0];
                n_found = 1'b1;
            end
        end
    end

    assign out_ready = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_win_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && r_win_valid) begin
            r_out_index  <= n_found ? n_pick : '0;
            r_out_none   <= !n_found;
            r_out_ticket <= r_win_ticket;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.task_index = r_out_index;
    assign o_rsp.none_ready = r_out_none;
    assign o_rsp.ticket     = r_out_ticket;

endmodule

`default_nettype wire

FILE: src/wltp_mod_stage.sv
// One stage of the pipelined restoring modulo: retires DIV_STEP dividend bits
// per transaction and registers the partial remainder. Depends on wltp_pkg.
`default_nettype none

module wltp_mod_stage import wltp_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic [WEIGHT_W-1:0] i_divisor,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire t_div_data           i_data,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output t_div_data                o_data
);

    logic      r_valid;
    t_div_data r_data;
    t_div_data n_data;

    // Shift in one dividend bit at a time and subtract the divisor when it fits.
    always_comb begin
        logic [WEIGHT_W:0]   trial;
        logic [WEIGHT_W-1:0] rem;
        logic [DIV_W-1:0]    word;
        rem  = i_data.rem;
        word = i_data.word;
        for (int s = 0; s < DIV_STEP; s++) begin
            trial = {rem, word[DIV_W-1]};
            word  = {word[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, i_divisor}) begin
                trial = trial - {1'b0, i_divisor};
            end
            rem = trial[WEIGHT_W-1:0];
        end
        n_data.rem  = rem;
        n_data.word = word;
        n_data.mask = i_data.mask;
    end

    // The stage takes a new transaction when empty or when its content moves on.
    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

FILE: src/wltp_checker.sv
// Port-level assertions for the weighted lottery task picker and the bind
// that attaches them to the top level. Depends on wltp_pkg.
`default_nettype none

module wltp_checker import wltp_pkg::*; (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_cfg_ready,
    input wire logic                i_rsp_valid,
    input wire logic                i_rsp_ready,
    input wire logic [TASK_W-1:0]   i_rsp_task_index,
    input wire logic                i_rsp_none_ready,
    input wire logic [WEIGHT_W-1:0] i_rsp_ticket
);

    // Reset empties the pipeline, so no result is offered right after it.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result valid after reset");

    // A result that flags no ready task carries index zero.
    a_none_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_none_ready) |-> (i_rsp_task_index == '0))
        else $error("none_ready result with nonzero index");

    // A stalled result holds its payload.
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_task_index) && $stable(i_rsp_none_ready)
             && $stable(i_rsp_ticket)))
        else $error("stalled result changed");

    // Configuration writes are always taken.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_ready)
        else $error("configuration port not ready");

endmodule

bind weighted_lottery_task_picker wltp_checker u_wltp_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_cfg_ready      (i_cfg.ready),
    .i_rsp_valid      (o_rsp.valid),
    .i_rsp_ready      (o_rsp.ready),
    .i_rsp_task_index (o_rsp.task_index),
    .i_rsp_none_ready (o_rsp.none_ready),
    .i_rsp_ticket     (o_rsp.ticket)
);

`default_nettype wire

FILE: sim/wltp_pick_checker.sv
// Checker for the weighted lottery task picker: watches the request, result
// and register write channels, predicts each pick and compares it on arrival.
// Depends on wltp_pkg and the channel interfaces in wltp_ifs.
`default_nettype none

module wltp_pick_checker import wltp_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    wltp_req_if       i_req,
    wltp_cfg_if       i_cfg,
    wltp_rsp_if       i_rsp,
    input  wire logic i_drained,
    output int        o_outstanding,
    output int        o_errors
);

    // One expected pick, laid out like the result channel.
    typedef struct packed {
        logic [TASK_W-1:0]   task_index;
        logic                none_ready;
        logic [WEIGHT_W-1:0] ticket;
    } t_pick_result;

    // Shadow copy of the registers, kept in step with the write channel.
    logic [CNT_W-1:0]    task_count_q;
    logic [WEIGHT_W-1:0] cum_weight_q [MAX_TASKS];

    t_pick_result expected_picks [$];
    int           mismatch_count = 0;
    bit           drain_checked  = 1'b0;

    assign o_errors = mismatch_count;

    // Prints one line per mismatch, up to a cap, and always counts it.
    task automatic report_mismatch(input string msg);
        if (mismatch_count < 100) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatch_count++;
    endtask

    // Draws the ticket from the current weights and scans for a ready task.
    function automatic t_pick_result predict_pick(input logic [WORD_W-1:0] word,
                                                  input logic [MASK_W-1:0] mask);
        int unsigned  active;
        int unsigned  total;
        int unsigned  ticket;
        int unsigned  winner;
        int unsigned  slot;
        bit           hit;
        bit           found;
        t_pick_result pick;

        // A count of zero acts as one task, a count above the maximum as the maximum.
        if (task_count_q == '0) begin
            active = 1;
        end else if (task_count_q > MAX_TASKS) begin
            active = MAX_TASKS;
        end else begin
            active = task_count_q;
        end

        // A zero total weight gives ticket zero without dividing.
        total  = cum_weight_q[active - 1];
        ticket = (total != 0) ? (32'(word) % total) : 0;

        // First active task whose cumulative weight passes the ticket, else task 0.
        winner = 0;
        hit    = 1'b0;
        for (int i = 0; i < active; i++) begin
            if (!hit && cum_weight_q[i] > ticket) begin
                winner = i;
                hit    = 1'b1;
            end
        end

        // Scan forward from the winner, wrapping over the active tasks only.
        slot  = 0;
        found = 1'b0;
        for (int i = 0; i < active; i++) begin
            if (!found && mask[(winner + i) % active]) begin
                slot  = (winner + i) % active;
                found = 1'b1;
            end
        end

        pick.task_index = found ? TASK_W'(slot) : '0;
        pick.none_ready = ~found;
        pick.ticket     = WEIGHT_W'(ticket);
        return pick;
    endfunction

    // Track every transaction at the edge where it happens.
    always @(posedge i_clk) begin
        t_pick_result want;
        if (!i_rst_n) begin
            task_count_q = CNT_W'(MAX_TASKS);
            for (int i = 0; i < MAX_TASKS; i++) begin
                cum_weight_q[i] = WEIGHT_W'(i + 1);
            end
            expected_picks.delete();
        end else begin
            // Register writes; indexes past the last weight change nothing.
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == REG_TASK_COUNT) begin
                    task_count_q = i_cfg.data[CNT_W-1:0];
                end else if (i_cfg.index <= REG_CUM_WEIGHT_LAST) begin
                    cum_weight_q[i_cfg.index - REG_CUM_WEIGHT_BASE] = i_cfg.data;
                end
            end

            // Results are matched against the oldest pick still waiting.
            if (i_rsp.valid && i_rsp.ready) begin
                if (expected_picks.size() == 0) begin
                    report_mismatch($sformatf("result with no pick waiting: task %0d ticket %0d",
                                              i_rsp.task_index, i_rsp.ticket));
                end else begin
                    want = expected_picks.pop_front();
                    if (i_rsp.task_index !== want.task_index) begin
                        report_mismatch($sformatf("task_index got %0d expected %0d",
                                                  i_rsp.task_index, want.task_index));
                    end
                    if (i_rsp.none_ready !== want.none_ready) begin
                        report_mismatch($sformatf("none_ready got %0b expected %0b",
                                                  i_rsp.none_ready, want.none_ready));
                    end
                    if (i_rsp.ticket !== want.ticket) begin
                        report_mismatch($sformatf("ticket got %0d expected %0d",
                                                  i_rsp.ticket, want.ticket));
                    end
                end
            end

            // Each accepted request is predicted with the registers as they stand.
            if (i_req.valid && i_req.ready) begin
                expected_picks.push_back(predict_pick(i_req.random_word, i_req.ready_mask));
            end

            // Anything still waiting once the run has drained is a loss.
            if (i_drained && !drain_checked) begin
                drain_checked = 1'b1;
                if (expected_picks.size() != 0) begin
                    report_mismatch($sformatf("%0d picks never came out",
                                              expected_picks.size()));
                end
            end
        end
        o_outstanding <= expected_picks.size();
    end

endmodule

`default_nettype wire

FILE: sim/tb_weighted_lottery_task_picker.sv
// Testbench top for the weighted lottery task picker: clock, reset, request and
// register stimulus, result back-pressure and the verdict. Depends on wltp_pkg,
// wltp_ifs, the picker RTL and wltp_pick_checker.
`default_nettype none

module tb_weighted_lottery_task_picker;
    import wltp_pkg::*;

    localparam int ITEMS_PER_PHASE = 65;
    localparam int RANDOM_PHASES   = 20;
    localparam int BURST_PHASE     = 3;
    localparam int BURST_ITEMS     = 40;
    localparam int NO_IDLE_PHASE   = 7;
    localparam int HOLD_CYCLES     = 80;
    localparam int MAX_GAP         = 6;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 20;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic drained = 1'b0;

    // Shared controls between the request sender and the result receiver.
    bit no_idle      = 1'b0;
    bit burst        = 1'b0;
    bit hold_pending = 1'b0;

    int outstanding;
    int errors;
    int idle_cycles      = 0;
    int requests_sent    = 0;
    int settings_applied = 0;

    wltp_req_if req_if ();
    wltp_cfg_if cfg_if ();
    wltp_rsp_if rsp_if ();

    weighted_lottery_task_picker u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_if),
        .i_cfg   (cfg_if),
        .o_rsp   (rsp_if)
    );

    wltp_pick_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_req         (req_if),
        .i_cfg         (cfg_if),
        .i_rsp         (rsp_if),
        .i_drained     (drained),
        .o_outstanding (outstanding),
        .o_errors      (errors)
    );

    // Free-running clock, period 10.
    always #5 clk = ~clk;

    // Offers one request after a random gap and returns at its accepting edge.
    task automatic send_request(input logic [WORD_W-1:0] word, input logic [MASK_W-1:0] mask);
        int unsigned gap;
        gap = (no_idle || burst) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid       <= 1'b1;
        req_if.random_word <= word;
        req_if.ready_mask  <= mask;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        requests_sent++;
    endtask

    // Holds one register write until its transaction completes; valid stays up.
    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DAT_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= index;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
    endtask

    // Stops offering requests and waits until every pick has come back.
    task automatic wait_for_drain();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Reprograms all registers on an idle block, optionally poking an unused index.
    task automatic apply_setting(input logic [CNT_W-1:0] count,
                                 input logic [MAX_TASKS-1:0][WEIGHT_W-1:0] weights,
                                 input bit poke_unused);
        logic [CFG_DAT_W-1:0] noise;
        wait_for_drain();
        noise = CFG_DAT_W'($urandom);
        write_register(REG_TASK_COUNT, {noise[CFG_DAT_W-1:CNT_W], count});
        for (int i = 0; i < MAX_TASKS; i++) begin
            write_register(REG_CUM_WEIGHT_BASE + CFG_IDX_W'(i), weights[i]);
        end
        if (poke_unused) begin
            write_register(CFG_IDX_W'($urandom_range(REG_CUM_WEIGHT_LAST + 1,
                                                     (1 << CFG_IDX_W) - 1)),
                           CFG_DAT_W'($urandom));
        end
        cfg_if.valid <= 1'b0;
        settings_applied++;
    endtask

    // Result receiver: random stalls, one long hold-off on request.
    initial begin
        int unsigned stall;
        rsp_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_if.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_if.valid) @(posedge clk);
        end
    end

    // Watchdog: too long without any transaction ends the run.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                (cfg_if.valid && cfg_if.ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("weighted_lottery_task_picker regression: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Main stimulus: reset, directed corners, then random settings and requests.
    initial begin
        logic [CNT_W-1:0]                    count;
        logic [MAX_TASKS-1:0][WEIGHT_W-1:0]  weights;
        logic [WORD_W-1:0]                   word;
        logic [MASK_W-1:0]                   mask;
        int unsigned                         acc;
        int unsigned                         step;
        int unsigned                         style;

        req_if.valid       <= 1'b0;
        req_if.random_word <= '0;
        req_if.ready_mask  <= '0;
        cfg_if.valid       <= 1'b0;
        cfg_if.index       <= '0;
        cfg_if.data        <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset weights 1..4: all ready, none ready, wrap from the last task.
        send_request('0, '1);
        send_request('1, '0);
        send_request(WORD_W'(3), 4'b0001);
        send_request(WORD_W'(1), 4'b1000);

        // Count zero acts as one task; mask bits above it are ignored.
        apply_setting(CNT_W'(0), {4{16'hFFFF}}, 1'b0);
        send_request('1, 4'b1110);
        send_request(WORD_W'(65534), 4'b0001);
        send_request(WORD_W'(65535), '1);

        // Count above the maximum with all weights zero: ticket zero, winner task 0.
        apply_setting(CNT_W'(7), '0, 1'b1);
        send_request(WORD_W'(12345), '1);
        send_request('1, 4'b0100);
        send_request('0, '0);

        // Three tasks with non-monotonic weights; the fourth weight is not used.
        apply_setting(CNT_W'(3), {16'd0, 16'd9, 16'd2, 16'd5}, 1'b1);
        send_request(WORD_W'(8), 4'b0010);
        send_request(WORD_W'(3), 4'b1000);
        send_request('1, 4'b0111);

        // Two tasks, one tiny and one full-scale weight.
        apply_setting(CNT_W'(2), {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001}, 1'b0);
        send_request('1, 4'b0010);
        send_request('0, 4'b0010);
        send_request(WORD_W'(65535), 4'b1101);

        // Four tasks spanning the whole weight range.
        apply_setting(CNT_W'(4), {16'hFFFF, 16'hC000, 16'h8000, 16'h4000}, 1'b0);
        send_request('1, 4'b1001);
        send_request(WORD_W'(16'h4000), 4'b0100);
        send_request(WORD_W'(16'hBFFF), 4'b0010);

        // Random settings, mostly well-formed rising weights.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if ($urandom_range(0, 3) != 0) begin
                count = CNT_W'($urandom_range(1, MAX_TASKS));
            end else begin
                count = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
            end
            style = $urandom_range(0, 9);
            case ($urandom_range(0, 2))
                0:       step = 3;
                1:       step = 300;
                default: step = 16000;
            endcase
            acc = 0;
            for (int i = 0; i < MAX_TASKS; i++) begin
                if (style < 6) begin
                    acc = acc + $urandom_range(0, step);
                    if (acc > 65535) begin
                        acc = 65535;
                    end
                    weights[i] = WEIGHT_W'(acc);
                end else if (style < 8) begin
                    weights[i] = WEIGHT_W'($urandom);
                end else if (style == 8) begin
                    weights[i] = $urandom_range(0, 1) ? '1 : '0;
                end else begin
                    weights[i] = WEIGHT_W'($urandom_range(0, 3));
                end
            end
            apply_setting(count, weights, $urandom_range(0, 3) == 0);

            no_idle = (phase == NO_IDLE_PHASE);
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                // One burst runs back to back into a long result hold-off.
                if (phase == BURST_PHASE && k == 0) begin
                    hold_pending = 1'b1;
                end
                burst = (phase == BURST_PHASE) && (k < BURST_ITEMS);
                case ($urandom_range(0, 9))
                    0:       word = $urandom_range(0, 1) ? '1 : '0;
                    1:       word = WORD_W'($urandom_range(0, 140000));
                    default: word = WORD_W'($urandom);
                endcase
                if ($urandom_range(0, 9) == 0) begin
                    mask = $urandom_range(0, 1) ? '1 : '0;
                end else begin
                    mask = MASK_W'($urandom_range(0, (1 << MASK_W) - 1));
                end
                send_request(word, mask);
            end
            burst   = 1'b0;
            no_idle = 1'b0;
        end

        // Drain, let the pipeline settle, then have the checker look for leftovers.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        drained <= 1'b1;
        repeat (2) @(posedge clk);

        $display("Run covered %0d requests under %0d register settings,", requests_sent,
                 settings_applied + 1);
        $display("with corner weights, clamped task counts and a stalled-output burst.");
        if (errors == 0) begin
            $display("weighted_lottery_task_picker regression: pass");
        end else begin
            $display("weighted_lottery_task_picker regression: fail");
        end
        $finish;
    end

endmodule

`default_nettype wire
